FILE: design/bfns_pkg.sv
// ----------------------------------------------------------------------------
// bfns_pkg
// Shared types and constants of the nearest set bit search block.
// ----------------------------------------------------------------------------
package bfns_pkg;

    // field widths
    localparam int IDX_W        = 10;
    localparam int WORD_W       = 64;
    localparam int BIT_W        = 6;
    localparam int WSEL_W       = IDX_W - BIT_W;
    localparam int MAX_POS      = 1 << IDX_W;
    localparam int DEF_NUM_BITS = 1024;
    localparam int Q_DEPTH      = 4;

    // operation codes
    localparam logic OP_FLIP  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] index;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] nearest_position;
    } t_out_item;

endpackage

FILE: design/bfns_ram.sv
// ----------------------------------------------------------------------------
// bfns_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bfns_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bfns_front.sv
// ----------------------------------------------------------------------------
// bfns_front
// Accepts input items, drops flips outside the bitmap and queues the rest.
// ----------------------------------------------------------------------------
module bfns_front
    import bfns_pkg::*;
#(
    parameter int NUM_BITS = DEF_NUM_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    output logic     o_cmd_valid,
    input  logic     i_cmd_pop,
    output t_in_item o_cmd
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_in_item        r_q [Q_DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_cnt;
    logic            in_xfer, keep, push, pop;

    // classify: a flip beyond the bitmap has no effect
    assign in_xfer = i_in_valid && !o_in_stall;
    assign keep    = (i_in_data.op == OP_QUERY) || (32'(i_in_data.index) < NUM_BITS);
    assign push    = in_xfer && keep;
    assign pop     = i_cmd_pop && (r_cnt != '0);

    assign o_in_stall  = (r_cnt == CW'(Q_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rptr];

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) r_wptr <= r_wptr + 1'b1;
            if (pop)  r_rptr <= r_rptr + 1'b1;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= i_in_data;
        end
    end

endmodule

FILE: design/bfns_back.sv
// ----------------------------------------------------------------------------
// bfns_back
// Carries out flips and nearest queries on the word-organized bitmap.
// ----------------------------------------------------------------------------
module bfns_back
    import bfns_pkg::*;
#(
    parameter int NUM_BITS = DEF_NUM_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_pop,
    input  t_in_item  i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int EFF_BITS = (NUM_BITS < MAX_POS) ? NUM_BITS : MAX_POS;
    localparam int NWORDS   = (EFF_BITS + WORD_W - 1) / WORD_W;
    localparam int AW       = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_FLIP_WR = 3'd1;
    localparam logic [2:0] S_Q_RD    = 3'd2;
    localparam logic [2:0] S_Q_LAST  = 3'd3;
    localparam logic [2:0] S_Q_DONE  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_idx;
    logic [AW-1:0]     r_scan, n_scan;
    logic [AW-1:0]     r_proc;
    logic [NWORDS-1:0] r_wvalid;
    logic              r_word_ok;
    logic              r_lo_any, r_hi_any;
    logic [IDX_W-1:0]  r_lo_pos, r_hi_pos;
    logic              r_out_vld;
    t_out_item         r_out;

    logic [AW-1:0]     rd_addr;
    logic              rd_en;
    logic              we;
    logic [WORD_W-1:0] rdata, word, wdata;
    logic              proc_en;
    logic              out_free;

    // per-word search signals
    logic [WSEL_W-1:0] cw, iw;
    logic [BIT_W-1:0]  ib;
    logic [WORD_W-1:0] mask_le, mask_ge, bits_le, bits_ge;
    logic [BIT_W-1:0]  hi_bit, lo_bit;
    logic [IDX_W-1:0]  dist_lo, dist_hi;
    t_out_item         res;

    function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) r = BIT_W'(i);
        end
        return r;
    endfunction

    function automatic logic [BIT_W-1:0] bottom_bit(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) r = BIT_W'(i);
        end
        return r;
    endfunction

    // bitmap words
    bfns_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_proc),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // a word never written reads as cleared
    assign word     = r_word_ok ? rdata : '0;
    assign out_free = !r_out_vld || !i_out_stall;

    // flip data
    assign wdata = word ^ (WORD_W'(1) << r_idx[BIT_W-1:0]);
    assign we    = (r_state == S_FLIP_WR);

    // scan word classification against the query index
    assign cw      = WSEL_W'(r_proc);
    assign iw      = r_idx[IDX_W-1:BIT_W];
    assign ib      = r_idx[BIT_W-1:0];
    assign mask_le = (cw < iw) ? '1 : (cw == iw) ? ({WORD_W{1'b1}} >> (~ib)) : '0;
    assign mask_ge = (cw > iw) ? '1 : (cw == iw) ? ({WORD_W{1'b1}} << ib) : '0;
    assign bits_le = word & mask_le;
    assign bits_ge = word & mask_ge;
    assign hi_bit  = top_bit(bits_le);
    assign lo_bit  = bottom_bit(bits_ge);
    assign proc_en = (r_state == S_Q_RD) || (r_state == S_Q_LAST);

    // final pick, lower position on equal distance
    assign dist_lo = r_idx - r_lo_pos;
    assign dist_hi = r_hi_pos - r_idx;
    always_comb begin
        res.found            = r_lo_any || r_hi_any;
        res.nearest_position = '0;
        if (r_lo_any && r_hi_any) begin
            res.nearest_position = (dist_lo <= dist_hi) ? r_lo_pos : r_hi_pos;
        end else if (r_lo_any) begin
            res.nearest_position = r_lo_pos;
        end else if (r_hi_any) begin
            res.nearest_position = r_hi_pos;
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_scan    = r_scan;
        rd_addr   = r_scan;
        rd_en     = 1'b0;
        o_cmd_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    rd_en     = 1'b1;
                    if (i_cmd.op == OP_FLIP) begin
                        rd_addr = AW'(i_cmd.index[IDX_W-1:BIT_W]);
                        n_state = S_FLIP_WR;
                    end else begin
                        rd_addr = '0;
                        n_scan  = AW'(1);
                        n_state = (NWORDS == 1) ? S_Q_LAST : S_Q_RD;
                    end
                end
            end
            S_FLIP_WR: begin
                n_state = S_IDLE;
            end
            S_Q_RD: begin
                rd_en = 1'b1;
                if (r_scan == AW'(NWORDS - 1)) begin
                    n_state = S_Q_LAST;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_Q_LAST: begin
                n_state = S_Q_DONE;
            end
            S_Q_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wvalid  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (we) r_wvalid[r_proc] <= 1'b1;
            if (r_state == S_Q_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // item and search registers
    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        if (rd_en) begin
            r_proc    <= rd_addr;
            r_word_ok <= r_wvalid[rd_addr];
        end
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_idx    <= i_cmd.index;
            r_lo_any <= 1'b0;
            r_hi_any <= 1'b0;
        end else if (proc_en) begin
            if (bits_le != '0) begin
                r_lo_any <= 1'b1;
                r_lo_pos <= {cw, hi_bit};
            end
            if (bits_ge != '0 && !r_hi_any) begin
                r_hi_any <= 1'b1;
                r_hi_pos <= {cw, lo_bit};
            end
        end
        if (r_state == S_Q_DONE && out_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

FILE: design/bitmap_flip_nearest_set_search.sv
// ----------------------------------------------------------------------------
// bitmap_flip_nearest_set_search
// Flippable bitmap with a nearest set bit query.
// ----------------------------------------------------------------------------
// Items enter a four-entry queue and are carried out one at a time on a
// bitmap held as 64-bit words in a RAM, min(NUM_BITS, 1024)/64 words deep
// (rounded up). A flip reads its word, then writes it back. A query reads
// every word once through the single read port; its result goes to the
// output register and waits there while the output is stalled, which holds
// off the next item. Flips give no result. Per-word valid bits clear the
// bitmap at reset at once, so no clearing pass is needed.
module bitmap_flip_nearest_set_search
    import bfns_pkg::*;
#(
    parameter int NUM_BITS = DEF_NUM_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic     cmd_valid;
    logic     cmd_pop;
    t_in_item cmd;

    // accept and queue
    bfns_front #(
        .NUM_BITS (NUM_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    // flip and search
    bfns_back #(
        .NUM_BITS (NUM_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
